/* sv/rsbh_pkg.sv */
package rsbh_pkg;

  localparam int BIN_BITS    = 3;
  localparam int ACC_BITS    = 40;
  localparam int WEIGHT_BITS = 24;

  localparam int SUB_BITS    = 8 - BIN_BITS;
  localparam int BINS_PER_CH = (1 << BIN_BITS) + 1;
  localparam int NUM_BINS    = BINS_PER_CH * BINS_PER_CH * BINS_PER_CH;
  localparam int ADDR_BITS   = $clog2(NUM_BINS);
  // per-axis weight 0 .. 2^SUB_BITS, product 0 .. 2^(3*SUB_BITS)
  localparam int H_BITS      = SUB_BITS + 1;
  localparam int W_BITS      = 3 * SUB_BITS + 1;
  localparam int STEP_BITS   = 3;

  localparam logic [STEP_BITS-1:0] LAST_STEP = '1;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  localparam logic [ACC_BITS-1:0]    ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic [ACC_BITS-1:0]    ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic [WEIGHT_BITS-1:0] PW_MAX  = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic [WEIGHT_BITS-1:0] PW_MIN  = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic [ADDR_BITS-1:0]   LAST_BIN = ADDR_BITS'(NUM_BINS - 1);

  typedef struct packed {
    logic                 load;       // capture the request at the input
    logic                 upd_issue;  // read one neighbour bin for update
    logic [STEP_BITS-1:0] step;       // neighbour number {dr, dg, db}
    logic                 rd_issue;   // read the requested bin
    logic                 clr_wr;     // write zero at clr_addr
    logic [ADDR_BITS-1:0] clr_addr;
    logic                 finish;     // load the result register
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic out_free;
  } stat_t;

  function automatic logic [ADDR_BITS-1:0] step_offset(input logic [STEP_BITS-1:0] k);
    int off;
    off = int'(k[2]) * BINS_PER_CH * BINS_PER_CH + int'(k[1]) * BINS_PER_CH + int'(k[0]);
    return ADDR_BITS'(off);
  endfunction

  // lower neighbour gets 2^S - f, upper neighbour gets f
  function automatic logic [H_BITS-1:0] axis_weight(input logic [SUB_BITS-1:0] f,
                                                   input logic upper);
    logic [H_BITS-1:0] fe;
    fe = {1'b0, f};
    return upper ? fe : (H_BITS'(1 << SUB_BITS) - fe);
  endfunction

endpackage

/* sv/rsbh_ram.sv */
module rsbh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/rsbh_ctrl.sv */
module rsbh_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      action,
  output logic            in_stall,
  input  rsbh_pkg::stat_t stat,
  output rsbh_pkg::cmd_t  cmd
);
  import rsbh_pkg::*;

  localparam logic [2:0] S_INIT = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]           state, state_next;
  logic [STEP_BITS-1:0] step, step_next;
  logic [ADDR_BITS-1:0] clr_cnt, clr_cnt_next;
  logic                 last_step;

  // simple mode touches one bin only
  assign last_step = (step == LAST_STEP) || !stat.mode;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    step_next    = step;
    clr_cnt_next = clr_cnt;
    cmd          = '0;
    cmd.step     = step;
    cmd.clr_addr = clr_cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (action) inside
            ACT_INSERT, ACT_REMOVE: begin
              state_next = S_UPD;
              step_next  = '0;
            end
            ACT_READ: state_next = S_RD;
            default: begin
              state_next   = S_CLR;
              clr_cnt_next = '0;
            end
          endcase
        end
      end
      S_UPD: begin
        cmd.upd_issue = 1'b1;
        if (last_step) begin
          state_next = S_FIN;
        end else begin
          step_next = step + STEP_BITS'(1);
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_FIN;
      end
      S_CLR, S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (clr_cnt == LAST_BIN) begin
          state_next = (state == S_CLR) ? S_FIN : S_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + ADDR_BITS'(1);
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      step    <= '0;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      clr_cnt <= clr_cnt_next;
    end
  end

endmodule

/* sv/rsbh_datapath.sv */
module rsbh_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic                                    cfg_wr_data,
  input  logic [1:0]                              action,
  input  logic [7:0]                              red,
  input  logic [7:0]                              green,
  input  logic [7:0]                              blue,
  input  logic [9:0]                              bin_index,
  input  rsbh_pkg::cmd_t                          cmd,
  output rsbh_pkg::stat_t                         stat,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [rsbh_pkg::ACC_BITS-1:0]    bin_value,
  output logic signed [rsbh_pkg::WEIGHT_BITS-1:0] total_weight,
  output logic                                    status
);
  import rsbh_pkg::*;

  logic                   histo_mode;
  logic [1:0]             act_q;
  logic                   sign_q;
  logic [ADDR_BITS-1:0]   base_q;
  logic [SUB_BITS-1:0]    fr_q, fg_q, fb_q;
  logic [ADDR_BITS-1:0]   idx_q;
  logic                   idx_ok_q;
  logic [WEIGHT_BITS-1:0] pixel_weight;

  // write half of the read-modify-write
  logic                   wr_valid;
  logic [ADDR_BITS-1:0]   wr_addr;
  logic [2*H_BITS-1:0]    wr_hrg;
  logic [H_BITS-1:0]      wr_hb;

  logic [H_BITS-1:0]             hr, hg, hb;
  logic [ADDR_BITS-1:0]          upd_addr;
  logic                          ram_re;
  logic [ADDR_BITS-1:0]          ram_raddr;
  logic [ACC_BITS-1:0]           ram_rdata;
  logic                          ram_we;
  logic [ADDR_BITS-1:0]          ram_waddr;
  logic [ACC_BITS-1:0]           ram_wdata;
  logic [3*H_BITS-1:0]           prod;
  logic signed [W_BITS:0]        delta;
  logic signed [ACC_BITS:0]      sum;
  logic [ACC_BITS-1:0]           sat_val;
  logic                          idx_ok;
  logic                          is_read;

  assign idx_ok = (32'(bin_index) < 32'(NUM_BINS));

  assign stat.mode     = histo_mode;
  assign stat.out_free = !out_valid || !out_stall;

  assign hr       = axis_weight(fr_q, cmd.step[2]);
  assign hg       = axis_weight(fg_q, cmd.step[1]);
  assign hb       = axis_weight(fb_q, cmd.step[0]);
  assign upd_addr = base_q + step_offset(cmd.step);

  assign ram_re    = cmd.upd_issue || (cmd.rd_issue && idx_ok_q);
  assign ram_raddr = cmd.upd_issue ? upd_addr : idx_q;

  assign prod  = (3*H_BITS)'(wr_hrg) * (3*H_BITS)'(wr_hb);
  assign delta = sign_q ? -(W_BITS+1)'(W_BITS'(prod)) : (W_BITS+1)'(W_BITS'(prod));
  assign sum   = (ACC_BITS+1)'(signed'(ram_rdata)) + (ACC_BITS+1)'(delta);

  always_comb begin
    if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
      sat_val = sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_val = sum[ACC_BITS-1:0];
    end
  end

  assign ram_we    = wr_valid || cmd.clr_wr;
  assign ram_waddr = cmd.clr_wr ? cmd.clr_addr : wr_addr;
  assign ram_wdata = cmd.clr_wr ? '0 : sat_val;

  rsbh_ram #(
    .WIDTH (ACC_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign is_read = (act_q == ACT_READ);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q    <= action;
      sign_q   <= (action == ACT_REMOVE);
      base_q   <= ADDR_BITS'(int'(red[7:SUB_BITS]) * BINS_PER_CH * BINS_PER_CH
                             + int'(green[7:SUB_BITS]) * BINS_PER_CH
                             + int'(blue[7:SUB_BITS]));
      // zero fraction in simple mode gives the full unit to the base bin
      fr_q     <= histo_mode ? red[SUB_BITS-1:0]   : '0;
      fg_q     <= histo_mode ? green[SUB_BITS-1:0] : '0;
      fb_q     <= histo_mode ? blue[SUB_BITS-1:0]  : '0;
      idx_q    <= ADDR_BITS'(bin_index);
      idx_ok_q <= idx_ok;
    end
    wr_addr <= upd_addr;
    wr_hrg  <= (2*H_BITS)'(hr) * (2*H_BITS)'(hg);
    wr_hb   <= hb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      histo_mode   <= 1'b0;
      pixel_weight <= '0;
      wr_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        histo_mode <= cfg_wr_data;
      end
      wr_valid <= cmd.upd_issue;
      if (cmd.load) begin
        case (action)
          ACT_INSERT: begin
            if (pixel_weight != PW_MAX) pixel_weight <= pixel_weight + WEIGHT_BITS'(1);
          end
          ACT_REMOVE: begin
            if (pixel_weight != PW_MIN) pixel_weight <= pixel_weight - WEIGHT_BITS'(1);
          end
          ACT_CLEAR: pixel_weight <= '0;
          default: ;
        endcase
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      bin_value    <= (is_read && idx_ok_q) ? signed'(ram_rdata) : '0;
      total_weight <= signed'(pixel_weight);
      status       <= is_read && !idx_ok_q;
    end
  end

endmodule

/* sv/rgb_soft_binned_histogram_top.sv */
// Channel  | Valid     | Stall     | Payload
// request  | in_valid  | in_stall  | action, red, green, blue, bin_index
// result   | out_valid | out_stall | bin_value, total_weight, status
// config   | cfg_wr_en | -         | cfg_wr_data (histo_mode)
//
// Simple insert/remove updates the base bin only; interpolated insert/remove performs
// eight bin read-modify-writes through the bin store, one bin per cycle.
// Clear zeroes all 729 bins, one bin per cycle. After reset a clearing pass over all
// 729 bins runs with in_stall high. A new request is taken while a result waits;
// the block then holds its result stage until out_stall drops.
module rgb_soft_binned_histogram_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_wr_en,
  input  logic                                    cfg_wr_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              action,
  input  logic [7:0]                              red,
  input  logic [7:0]                              green,
  input  logic [7:0]                              blue,
  input  logic [9:0]                              bin_index,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [rsbh_pkg::ACC_BITS-1:0]    bin_value,
  output logic signed [rsbh_pkg::WEIGHT_BITS-1:0] total_weight,
  output logic                                    status
);
  import rsbh_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rsbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  rsbh_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .action       (action),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .bin_index    (bin_index),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bin_value    (bin_value),
    .total_weight (total_weight),
    .status       (status)
  );

endmodule
